// ----- sv/lldd_pkg.sv -----
// lldd_pkg: types, constants and codes for the least-loaded backend dispatcher
// no dependencies
package lldd_pkg;

  localparam int NUM_BACKENDS_DEF = 3;
  localparam int QUEUE_DEPTH_DEF  = 128;

  localparam logic [15:0] LISTEN_PORT_RST  = 16'd8080;
  localparam logic [7:0]  THREAD_LIMIT_RST = 8'd5;
  localparam logic [15:0] ETH_IPV4         = 16'h0800;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [10:0] LEN_BACKEND      = 11'd1;
  localparam logic [10:0] LEN_JOB          = 11'd8;

  typedef enum logic [1:0] {
    V_PASS  = 2'd0,
    V_DROP  = 2'd1,
    V_TX    = 2'd2,
    V_ABORT = 2'd3
  } verdict_t;

  typedef enum logic [0:0] {
    REG_LISTEN_PORT  = 1'b0,
    REG_THREAD_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_ABORT   = 2'd0,
    K_PASS    = 2'd1,
    K_BACKEND = 2'd2,
    K_JOB     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [63:0] job;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  backend_index;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [47:0] out_src_mac;
    logic [47:0] out_dst_mac;
    logic [63:0] out_payload_word;
    logic        queue_overflow;
  } res_t;

endpackage

// ----- sv/lldd_if.sv -----
// lldd_if: valid/ready channel carrying a packed payload
// depends on nothing; payload type given as a parameter
interface lldd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/lldd_ram.sv -----
// lldd_ram: generic single-port-write, single-read RAM, registered read
// no dependencies
module lldd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/lldd_front.sv -----
// lldd_front: accepts headers, classifies them, fills a two-entry command queue
// depends on lldd_pkg
module lldd_front import lldd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        headers_truncated,
  input  logic [15:0] ethertype,
  input  logic [7:0]  ip_protocol,
  input  logic [15:0] dest_port,
  input  logic [10:0] payload_length,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [47:0] src_mac,
  input  logic [47:0] dst_mac,
  input  logic [63:0] payload_word,
  input  logic [15:0] listen_port,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  cmd_t q_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  cmd_t c;
  logic push, pop;

  always_comb begin
    c.src_ip  = src_ip;
    c.dst_ip  = dst_ip;
    c.src_mac = src_mac;
    c.dst_mac = dst_mac;
    c.job     = payload_word;
    priority if (headers_truncated) c.kind = K_ABORT;
    else if (ethertype != ETH_IPV4 || ip_protocol != PROTO_UDP || dest_port != listen_port)
      c.kind = K_PASS;
    else if (payload_length == LEN_BACKEND) c.kind = K_BACKEND;
    else if (payload_length == LEN_JOB) c.kind = K_JOB;
    else c.kind = K_PASS;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- sv/lldd_back.sv -----
// lldd_back: backend table, job queue and result register
// depends on lldd_pkg and lldd_ram
module lldd_back import lldd_pkg::*; #(
  parameter int NUM_BACKENDS = NUM_BACKENDS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] thread_limit,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);
  localparam int BW = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0] bip_r   [NUM_BACKENDS];
  logic [31:0] blip_r  [NUM_BACKENDS];
  logic [47:0] bmac_r  [NUM_BACKENDS];
  logic [7:0]  free_r  [NUM_BACKENDS];
  logic [BW:0] regc_r;
  logic [AW-1:0] head_r, tail_r;
  logic [FW-1:0] fill_r;
  state_t st_r, st_nxt;
  cmd_t   c_r;
  res_t   res_r, res_nxt;

  logic hit;
  logic [BW-1:0] hit_idx;
  logic sel_ok;
  logic [BW-1:0] sel;
  logic [7:0] best;
  logic [7:0] free_v [NUM_BACKENDS];
  logic [7:0] inc;
  logic q_we;
  logic [63:0] q_rdata;
  logic [AW-1:0] q_raddr;

  lldd_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_q (
    .clk(clk), .we(q_we), .waddr(tail_r), .wdata(c_r.job),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  assign q_raddr = head_r;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int k = NUM_BACKENDS - 1; k >= 0; k--) begin
      if (bip_r[k] != 32'd0 && bip_r[k] == c_r.src_ip) begin
        hit = 1'b1;
        hit_idx = BW'(k);
      end
    end
  end

  // free counts after a completion, as seen by the selection
  always_comb begin
    inc = free_r[hit_idx] + 8'd1;
    for (int k = 0; k < NUM_BACKENDS; k++) free_v[k] = free_r[k];
    if (c_r.kind == K_BACKEND && hit)
      free_v[hit_idx] = (inc > thread_limit || inc == 8'd0) ? thread_limit : inc;
  end

  always_comb begin
    sel_ok = 1'b0;
    sel = '0;
    best = 8'd0;
    for (int k = 0; k < NUM_BACKENDS; k++) begin
      if (bip_r[k] != 32'd0 && free_v[k] > best) begin
        best = free_v[k];
        sel = BW'(k);
        sel_ok = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (st_r)
      ST_IDLE: st_nxt = cmd_valid ? ST_EXEC : ST_IDLE;
      ST_EXEC: st_nxt = ST_OUT;
      ST_OUT:  st_nxt = res_ready ? ST_IDLE : ST_OUT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (st_r == ST_IDLE);
    res_valid = (st_r == ST_OUT);
    res = res_r;
  end

  always_comb begin
    res_nxt = '0;
    q_we = 1'b0;
    unique case (c_r.kind)
      K_ABORT: res_nxt.verdict = V_ABORT;
      K_PASS:  res_nxt.verdict = V_PASS;
      K_BACKEND: begin
        res_nxt.verdict = V_DROP;
        if (c_r.src_ip != 32'd0 && hit && fill_r != '0) begin
          if (sel_ok) begin
            res_nxt.verdict = V_TX;
            res_nxt.out_payload_word = q_rdata;
          end else begin
            res_nxt.verdict = V_ABORT;
          end
        end
      end
      K_JOB: begin
        if (sel_ok) begin
          res_nxt.verdict = V_TX;
          res_nxt.out_payload_word = c_r.job;
        end else begin
          res_nxt.verdict = V_ABORT;
          q_we = (st_r == ST_EXEC) && (fill_r != FW'(QUEUE_DEPTH));
          res_nxt.queue_overflow = (fill_r == FW'(QUEUE_DEPTH));
        end
      end
      default: res_nxt.verdict = V_PASS;
    endcase
    if (res_nxt.verdict == V_TX) begin
      res_nxt.backend_index = 2'(sel);
      res_nxt.out_src_ip = blip_r[sel];
      res_nxt.out_dst_ip = bip_r[sel];
      res_nxt.out_src_mac = c_r.dst_mac;
      res_nxt.out_dst_mac = bmac_r[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) c_r <= cmd;
    if (st_r == ST_EXEC) res_r <= res_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      regc_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      for (int k = 0; k < NUM_BACKENDS; k++) begin
        bip_r[k] <= '0; blip_r[k] <= '0; bmac_r[k] <= '0; free_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_EXEC) begin
        if (c_r.kind == K_BACKEND && c_r.src_ip != 32'd0) begin
          if (!hit) begin
            if (regc_r < (BW+1)'(NUM_BACKENDS)) begin
              bip_r[regc_r[BW-1:0]]  <= c_r.src_ip;
              blip_r[regc_r[BW-1:0]] <= c_r.dst_ip;
              bmac_r[regc_r[BW-1:0]] <= c_r.src_mac;
              free_r[regc_r[BW-1:0]] <= thread_limit;
              regc_r <= regc_r + 1'b1;
            end
          end else begin
            for (int k = 0; k < NUM_BACKENDS; k++)
              free_r[k] <= (fill_r != '0 && sel_ok && BW'(k) == sel) ?
                           free_v[k] - 8'd1 : free_v[k];
            if (fill_r != '0 && sel_ok) begin
              head_r <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
              fill_r <= fill_r - 1'b1;
            end
          end
        end
        if (c_r.kind == K_JOB) begin
          if (sel_ok) free_r[sel] <= free_r[sel] - 8'd1;
          else if (q_we) begin
            tail_r <= (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            fill_r <= fill_r + 1'b1;
          end
        end
      end
    end
  end
endmodule

// ----- sv/least_loaded_backend_dispatcher_unit.sv -----
// least_loaded_backend_dispatcher_unit: top level of the dispatcher
// each input is registered in the front queue; the back end then captures it and registers its result
// its idle/execute/output sequence around the queue ram read takes no command while a result waits
// the front queue of two commands lets inputs be taken while a result waits
// rst_n synchronous active low clears table, queue pointers and config to defaults
// depends on lldd_pkg, lldd_if, lldd_ram, lldd_front, lldd_back
module least_loaded_backend_dispatcher_unit import lldd_pkg::*; #(
  parameter int NUM_BACKENDS = NUM_BACKENDS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_headers_truncated,
  input  logic [15:0] in_ethertype,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [10:0] in_payload_length,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [47:0] in_src_mac,
  input  logic [47:0] in_dst_mac,
  input  logic [63:0] in_payload_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  output logic [1:0]  out_backend_index,
  output logic [31:0] out_out_src_ip,
  output logic [31:0] out_out_dst_ip,
  output logic [47:0] out_out_src_mac,
  output logic [47:0] out_out_dst_mac,
  output logic [63:0] out_out_payload_word,
  output logic        out_queue_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] listen_port_r;
  logic [7:0]  thread_limit_r;

  lldd_if #(.payload_t(cmd_t)) cmd_ch ();
  lldd_if #(.payload_t(res_t)) res_ch ();

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r  <= LISTEN_PORT_RST;
      thread_limit_r <= THREAD_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LISTEN_PORT:  listen_port_r  <= cfg_data;
        REG_THREAD_LIMIT: thread_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lldd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .headers_truncated(in_headers_truncated), .ethertype(in_ethertype),
    .ip_protocol(in_ip_protocol), .dest_port(in_dest_port),
    .payload_length(in_payload_length), .src_ip(in_src_ip), .dst_ip(in_dst_ip),
    .src_mac(in_src_mac), .dst_mac(in_dst_mac), .payload_word(in_payload_word),
    .listen_port(listen_port_r),
    .cmd_valid(cmd_ch.valid), .cmd_ready(cmd_ch.ready), .cmd(cmd_ch.data)
  );

  lldd_back #(.NUM_BACKENDS(NUM_BACKENDS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .thread_limit(thread_limit_r),
    .cmd_valid(cmd_ch.valid), .cmd_ready(cmd_ch.ready), .cmd(cmd_ch.data),
    .res_valid(res_ch.valid), .res_ready(res_ch.ready), .res(res_ch.data)
  );

  assign res_ch.ready         = out_ready;
  assign out_valid            = res_ch.valid;
  assign out_verdict          = res_ch.data.verdict;
  assign out_backend_index    = res_ch.data.backend_index;
  assign out_out_src_ip       = res_ch.data.out_src_ip;
  assign out_out_dst_ip       = res_ch.data.out_dst_ip;
  assign out_out_src_mac      = res_ch.data.out_src_mac;
  assign out_out_dst_mac      = res_ch.data.out_dst_mac;
  assign out_out_payload_word = res_ch.data.out_payload_word;
  assign out_queue_overflow   = res_ch.data.queue_overflow;

  a_tx_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_TX |-> out_backend_index < 2'(NUM_BACKENDS))
    else $error("transmit to a backend outside the table");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_overflow |-> out_verdict == V_ABORT)
    else $error("overflow flagged without aborted verdict");
  a_nontx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != V_TX |-> out_out_payload_word == 64'd0)
    else $error("payload on a non-transmit result");
endmodule

// ----- test/lldd_tb_pkg.sv -----
// lldd_tb_pkg: packed header and register-write types used by the dispatcher testbench
// depends on lldd_pkg for the register index codes
package lldd_tb_pkg;
  import lldd_pkg::*;

  typedef struct packed {
    logic        truncated;
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic [10:0] payload_length;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [63:0] payload_word;
  } hdr_t;

  typedef struct packed {
    reg_idx_t    index;
    logic [15:0] data;
  } reg_wr_t;

endpackage

// ----- test/dispatch_chan_if.sv -----
// dispatch_chan_if: valid/ready channel used by the testbench for every port group
// payload type is a parameter; no other dependencies
interface dispatch_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- test/dispatch_checker.sv -----
// dispatch_checker: tracks backend table and job queue, predicts each verdict and compares
// depends on lldd_pkg, lldd_tb_pkg and dispatch_chan_if
module dispatch_checker import lldd_pkg::*, lldd_tb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  dispatch_chan_if hdr_ch,
  dispatch_chan_if res_ch,
  dispatch_chan_if reg_ch,
  output int       fail_count,
  output int       outstanding
);
  localparam int NB = 3;
  localparam int QD = 128;

  logic [15:0] port_reg;
  logic [7:0]  limit_reg;
  logic [31:0] tbl_ip [NB];
  logic [31:0] tbl_local_ip [NB];
  logic [47:0] tbl_mac [NB];
  logic [7:0]  tbl_free [NB];
  int          n_registered;
  logic [63:0] jobs [QD];
  int          q_head, q_tail, q_fill;
  res_t        expected_q [$];

  function automatic int most_free();
    int   sel;
    logic [7:0] best;
    sel = -1;
    best = 0;
    for (int i = 0; i < NB; i++)
      if (tbl_ip[i] != 0 && tbl_free[i] > best) begin
        best = tbl_free[i];
        sel = i;
      end
    return sel;
  endfunction

  function automatic res_t send_job(int sel, logic [47:0] dmac, logic [63:0] job);
    res_t r;
    r = '0;
    tbl_free[sel] = tbl_free[sel] - 8'd1;
    r.verdict = V_TX;
    r.backend_index = sel[1:0];
    r.out_src_ip = tbl_local_ip[sel];
    r.out_dst_ip = tbl_ip[sel];
    r.out_src_mac = dmac;
    r.out_dst_mac = tbl_mac[sel];
    r.out_payload_word = job;
    return r;
  endfunction

  function automatic res_t dispatch(hdr_t h);
    res_t r;
    int   slot, sel;
    logic [63:0] v;
    r = '0;
    slot = -1;
    if (h.truncated) begin
      r.verdict = V_ABORT;
      return r;
    end
    r.verdict = V_PASS;
    if (h.ethertype != ETH_IPV4 || h.ip_protocol != PROTO_UDP || h.dest_port != port_reg)
      return r;
    if (h.payload_length == LEN_BACKEND) begin
      r.verdict = V_DROP;
      if (h.src_ip == 0) return r;
      for (int k = 0; k < n_registered; k++)
        if (tbl_ip[k] == h.src_ip && slot < 0) slot = k;
      if (slot < 0) begin
        if (n_registered < NB) begin
          tbl_ip[n_registered] = h.src_ip;
          tbl_local_ip[n_registered] = h.dst_ip;
          tbl_mac[n_registered] = h.src_mac;
          tbl_free[n_registered] = limit_reg;
          n_registered++;
        end
        return r;
      end
      tbl_free[slot] = (tbl_free[slot] >= limit_reg) ? limit_reg : tbl_free[slot] + 8'd1;
      if (q_fill == 0) return r;
      sel = most_free();
      if (sel < 0) begin
        r.verdict = V_ABORT;
        return r;
      end
      v = jobs[q_head];
      q_head = (q_head + 1) % QD;
      q_fill--;
      return send_job(sel, h.dst_mac, v);
    end
    if (h.payload_length == LEN_JOB) begin
      sel = most_free();
      if (sel >= 0) return send_job(sel, h.dst_mac, h.payload_word);
      r.verdict = V_ABORT;
      if (q_fill < QD) begin
        jobs[q_tail] = h.payload_word;
        q_tail = (q_tail + 1) % QD;
        q_fill++;
      end else
        r.queue_overflow = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    res_t e, a;
    if (!rst_n) begin
      port_reg = LISTEN_PORT_RST;
      limit_reg = THREAD_LIMIT_RST;
      for (int i = 0; i < NB; i++) begin
        tbl_ip[i] = 0;
        tbl_local_ip[i] = 0;
        tbl_mac[i] = 0;
        tbl_free[i] = 0;
      end
      n_registered = 0;
      q_head = 0;
      q_tail = 0;
      q_fill = 0;
      expected_q.delete();
    end else begin
      if (reg_ch.valid && reg_ch.ready) begin
        if (reg_ch.data.index == REG_LISTEN_PORT) port_reg = reg_ch.data.data;
        else limit_reg = reg_ch.data.data[7:0];
      end
      if (res_ch.valid && res_ch.ready) begin
        a = res_ch.data;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %h", a);
        end else begin
          e = expected_q.pop_front();
          check_field("verdict", 64'(e.verdict), 64'(a.verdict));
          check_field("backend_index", 64'(e.backend_index), 64'(a.backend_index));
          check_field("out_src_ip", 64'(e.out_src_ip), 64'(a.out_src_ip));
          check_field("out_dst_ip", 64'(e.out_dst_ip), 64'(a.out_dst_ip));
          check_field("out_src_mac", 64'(e.out_src_mac), 64'(a.out_src_mac));
          check_field("out_dst_mac", 64'(e.out_dst_mac), 64'(a.out_dst_mac));
          check_field("out_payload_word", e.out_payload_word, a.out_payload_word);
          check_field("queue_overflow", 64'(e.queue_overflow), 64'(a.queue_overflow));
        end
      end
      if (hdr_ch.valid && hdr_ch.ready) expected_q.push_back(dispatch(hdr_ch.data));
    end
    outstanding = expected_q.size();
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  final begin end
endmodule

// ----- test/tb_least_loaded_backend_dispatcher_unit.sv -----
// tb_least_loaded_backend_dispatcher_unit: stimulus, register phases and verdict
// depends on lldd_pkg, lldd_tb_pkg, dispatch_chan_if, dispatch_checker and the dispatcher
module tb_least_loaded_backend_dispatcher_unit;
  import lldd_pkg::*;
  import lldd_tb_pkg::*;

  localparam int LIMIT = 500000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   fail_count, outstanding;
  bit   quiet = 0;
  bit   long_hold = 0;
  logic [15:0] cur_port = LISTEN_PORT_RST;
  logic [31:0] ip_pool [4];

  dispatch_chan_if #(hdr_t)    hdr_ch ();
  dispatch_chan_if #(res_t)    res_ch ();
  dispatch_chan_if #(reg_wr_t) reg_ch ();

  always #6 clk = ~clk;

  least_loaded_backend_dispatcher_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(hdr_ch.valid), .in_ready(hdr_ch.ready),
    .in_headers_truncated(hdr_ch.data.truncated),
    .in_ethertype(hdr_ch.data.ethertype),
    .in_ip_protocol(hdr_ch.data.ip_protocol),
    .in_dest_port(hdr_ch.data.dest_port),
    .in_payload_length(hdr_ch.data.payload_length),
    .in_src_ip(hdr_ch.data.src_ip), .in_dst_ip(hdr_ch.data.dst_ip),
    .in_src_mac(hdr_ch.data.src_mac), .in_dst_mac(hdr_ch.data.dst_mac),
    .in_payload_word(hdr_ch.data.payload_word),
    .out_valid(res_ch.valid), .out_ready(res_ch.ready),
    .out_verdict(res_ch.data.verdict),
    .out_backend_index(res_ch.data.backend_index),
    .out_out_src_ip(res_ch.data.out_src_ip),
    .out_out_dst_ip(res_ch.data.out_dst_ip),
    .out_out_src_mac(res_ch.data.out_src_mac),
    .out_out_dst_mac(res_ch.data.out_dst_mac),
    .out_out_payload_word(res_ch.data.out_payload_word),
    .out_queue_overflow(res_ch.data.queue_overflow),
    .cfg_valid(reg_ch.valid), .cfg_ready(reg_ch.ready),
    .cfg_index(reg_ch.data.index), .cfg_data(reg_ch.data.data)
  );

  dispatch_checker u_checker (
    .clk(clk), .rst_n(rst_n), .hdr_ch(hdr_ch), .res_ch(res_ch), .reg_ch(reg_ch),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_least_loaded_backend_dispatcher_unit: FAIL");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic hdr_t well_formed(logic [10:0] len);
    hdr_t h;
    h.truncated = 1'b0;
    h.ethertype = ETH_IPV4;
    h.ip_protocol = PROTO_UDP;
    h.dest_port = cur_port;
    h.payload_length = len;
    h.src_ip = $urandom;
    h.dst_ip = $urandom;
    h.src_mac = 48'({$urandom, $urandom});
    h.dst_mac = 48'({$urandom, $urandom});
    h.payload_word = {$urandom, $urandom};
    return h;
  endfunction

  function automatic hdr_t backend_msg(logic [31:0] ip);
    hdr_t h;
    h = well_formed(LEN_BACKEND);
    h.src_ip = ip;
    return h;
  endfunction

  function automatic hdr_t random_item();
    hdr_t h;
    int   r;
    logic [287:0] rnd;
    r = $urandom_range(0, 99);
    if (r < 40) return well_formed(LEN_JOB);
    if (r < 72) return backend_msg(ip_pool[$urandom_range(0, 3)]);
    if (r < 76) return well_formed(LEN_BACKEND);
    h = well_formed($urandom_range(0, 1) ? LEN_JOB : LEN_BACKEND);
    case ($urandom_range(0, 6))
      0: begin
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        h = rnd[$bits(hdr_t)-1:0];
        h.payload_length = 11'($urandom_range(0, 1480));
      end
      1: h.truncated = 1'b1;
      2: h.ethertype = 16'($urandom);
      3: h.ip_protocol = 8'($urandom);
      4: h.dest_port = 16'($urandom);
      5: h.payload_length = 11'($urandom_range(0, 1480));
      default: h.src_ip = 0;
    endcase
    return h;
  endfunction

  task automatic send(hdr_t h);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      hdr_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    hdr_ch.valid <= 1'b1;
    hdr_ch.data <= h;
    do @(posedge clk); while (!hdr_ch.ready);
  endtask

  task automatic drain();
    hdr_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.data <= '{index: idx, data: val};
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_LISTEN_PORT) cur_port = val;
  endtask

  task automatic run_phase(logic [15:0] port, logic [7:0] lim, int n);
    drain();
    write_reg(REG_LISTEN_PORT, port);
    write_reg(REG_THREAD_LIMIT, {8'd0, lim});
    repeat (n) send(random_item());
  endtask

  initial begin
    hdr_t h;
    rst_n <= 1'b0;
    hdr_ch.valid <= 1'b0;
    hdr_ch.data <= '0;
    reg_ch.valid <= 1'b0;
    reg_ch.data <= '0;
    for (int i = 0; i < 4; i++) ip_pool[i] = $urandom | 32'h1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: header checks, odd lengths, address zero, job with no backend
    h = well_formed(LEN_JOB); h.truncated = 1'b1; send(h);
    h = '1; send(h);
    h = well_formed(LEN_JOB); h.ethertype = 16'h86DD; send(h);
    h = well_formed(LEN_JOB); h.ip_protocol = 8'd6; send(h);
    h = well_formed(LEN_JOB); h.dest_port = cur_port + 16'd1; send(h);
    send(well_formed(11'd0));
    send(well_formed(11'd1480));
    send(well_formed(11'd2));
    send(well_formed(11'd9));
    send(backend_msg(32'h0));
    h = well_formed(LEN_JOB); h.payload_word = '1; send(h);
    h = well_formed(LEN_JOB); h.payload_word = '0; send(h);

    // fill the job queue past its depth before any backend exists
    repeat (135) send(well_formed(LEN_JOB));

    // registrations, table full, completions draining the queue
    h = backend_msg(32'hFFFFFFFF); h.src_mac = '1; h.dst_ip = '1; send(h);
    send(backend_msg(ip_pool[0]));
    send(backend_msg(ip_pool[1]));
    send(backend_msg(ip_pool[2]));
    send(backend_msg(32'hFFFFFFFF));
    h = well_formed(LEN_JOB); h.dst_mac = '0; send(h);
    h = well_formed(LEN_JOB); h.dst_mac = '1; send(h);
    send(backend_msg(ip_pool[0]));

    long_hold = 1;
    repeat (150) send(random_item());
    run_phase(LISTEN_PORT_RST, THREAD_LIMIT_RST, 300);
    run_phase(16'd0, 8'd1, 250);
    run_phase(16'hFFFF, 8'd255, 250);
    run_phase(16'($urandom), 8'd0, 250);
    run_phase(16'($urandom), 8'($urandom_range(1, 255)), 250);
    drain();
    quiet = 1;
    run_phase(LISTEN_PORT_RST, 8'd3, 200);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("tb_least_loaded_backend_dispatcher_unit: PASS");
    else
      $display("tb_least_loaded_backend_dispatcher_unit: FAIL");
    $finish;
  end
endmodule
